// ----- rtl/core/jse_pkg.sv -----
`timescale 1ns / 1ps

package jse_pkg;

	// Escape forms a string byte can take
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PAIR,
		ESC_UNI
	} esc_t;

	// One classified input beat, as queued between front and back
	typedef struct packed {
		logic [7:0] char_byte;
		logic [7:0] letter;
		esc_t       esc;
		logic       has_byte;
		logic       is_first;
		logic       is_last;
	} desc_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int          TOTAL_W   = 20;
	localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CTRL_MAX  = 8'h1F;

	localparam logic [7:0] C_BS = 8'h08;
	localparam logic [7:0] C_HT = 8'h09;
	localparam logic [7:0] C_LF = 8'h0A;
	localparam logic [7:0] C_FF = 8'h0C;
	localparam logic [7:0] C_CR = 8'h0D;

	// Lowercase hex digit
	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'h0, nib};
		return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
	endfunction

endpackage

// ----- rtl/core/jse_in_if.sv -----
`timescale 1ns / 1ps

interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       has_byte;
	logic       is_first;
	logic       is_last;

	modport source (output valid, char_byte, has_byte, is_first, is_last, input ready);
	modport sink (input valid, char_byte, has_byte, is_first, is_last, output ready);
endinterface

// ----- rtl/core/jse_out_if.sv -----
`timescale 1ns / 1ps

interface jse_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        run_end;
	logic        string_done;
	logic [19:0] total_written;

	modport source (output valid, out_byte, run_end, string_done, total_written, input ready);
	modport sink (input valid, out_byte, run_end, string_done, total_written, output ready);
endinterface

// ----- rtl/core/jse_front.sv -----
`timescale 1ns / 1ps

module jse_front (
	jse_in_if.sink          in_bytes,
	input  logic            full,
	output logic            push,
	output jse_pkg::desc_t  push_desc
);

	logic [7:0]   c;
	jse_pkg::esc_t esc;
	logic [7:0]   letter;

	assign c = in_bytes.char_byte;

	// Classify the byte into its escape form
	always_comb begin
		esc    = jse_pkg::ESC_NONE;
		letter = c;
		if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
			esc = jse_pkg::ESC_PAIR;
		end else if (c <= jse_pkg::CTRL_MAX) begin
			esc    = jse_pkg::ESC_PAIR;
			case (c)
				jse_pkg::C_BS: letter = jse_pkg::CH_B;
				jse_pkg::C_FF: letter = jse_pkg::CH_F;
				jse_pkg::C_LF: letter = jse_pkg::CH_N;
				jse_pkg::C_CR: letter = jse_pkg::CH_R;
				jse_pkg::C_HT: letter = jse_pkg::CH_T;
				default: begin
					esc    = jse_pkg::ESC_UNI;
					letter = jse_pkg::CH_U;
				end
			endcase
		end
	end

	assign push_desc.char_byte = c;
	assign push_desc.letter    = letter;
	assign push_desc.esc       = esc;
	assign push_desc.has_byte  = in_bytes.has_byte;
	assign push_desc.is_first  = in_bytes.is_first;
	assign push_desc.is_last   = in_bytes.is_last;

	// Beats with nothing to emit are taken and dropped
	assign in_bytes.ready = !full;
	assign push = in_bytes.valid && !full &&
		(in_bytes.has_byte || in_bytes.is_first || in_bytes.is_last);

endmodule

// ----- rtl/core/jse_queue.sv -----
`timescale 1ns / 1ps

module jse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output jse_pkg::desc_t head
);

	jse_pkg::desc_t                 entry_q [jse_pkg::QUEUE_DEPTH];
	logic [jse_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [jse_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [jse_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == jse_pkg::QCNT_W'(jse_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue read while empty");

endmodule

// ----- rtl/core/jse_back.sv -----
`timescale 1ns / 1ps

module jse_back #(
	parameter int COUNT_BITS = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  jse_pkg::desc_t head,
	output logic           pop,
	jse_out_if.source      out_bytes
);

	localparam int WIDE_W = (COUNT_BITS > jse_pkg::TOTAL_W) ? COUNT_BITS : jse_pkg::TOTAL_W;

	logic [2:0]            idx_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  ovalid_q;
	logic [7:0]            out_byte_q;
	logic                  run_end_q;
	logic                  done_q;
	logic [19:0]           total_q;

	logic [2:0]            seq_len;
	logic [3:0]            n_beats;
	logic                  last_slot;
	logic [2:0]            elem;
	logic                  is_open;
	logic                  is_close;
	logic [7:0]            seq_byte;
	logic [7:0]            next_byte;
	logic [COUNT_BITS-1:0] count_inc;
	logic [WIDE_W-1:0]     total_wide;
	logic [19:0]           total_clamp;
	logic                  load;

	// Beat count of the head item: quotes plus escape sequence
	always_comb begin
		seq_len = 3'd0;
		if (head.has_byte) begin
			case (head.esc)
				jse_pkg::ESC_NONE: seq_len = 3'd1;
				jse_pkg::ESC_PAIR: seq_len = 3'd2;
				jse_pkg::ESC_UNI:  seq_len = 3'd6;
				default:           seq_len = 3'd1;
			endcase
		end
	end

	assign n_beats   = {3'b0, head.is_first} + {1'b0, seq_len} + {3'b0, head.is_last};
	assign last_slot = ({1'b0, idx_q} == n_beats - 4'd1);
	assign elem      = idx_q - {2'b0, head.is_first};
	assign is_open   = head.is_first && (idx_q == 3'd0);
	assign is_close  = head.is_last && last_slot;

	// Byte at position elem of the escape sequence
	always_comb begin
		case (elem)
			3'd0:    seq_byte = (head.esc == jse_pkg::ESC_NONE) ? head.char_byte
				: jse_pkg::CH_BSLASH;
			3'd1:    seq_byte = head.letter;
			3'd4:    seq_byte = jse_pkg::hex_lower(head.char_byte[7:4]);
			3'd5:    seq_byte = jse_pkg::hex_lower(head.char_byte[3:0]);
			default: seq_byte = jse_pkg::CH_ZERO;
		endcase
	end

	assign next_byte = (is_open || is_close) ? jse_pkg::CH_QUOTE : seq_byte;

	// Saturating count and the total reported on the closing quote
	assign count_inc   = (count_q == '1) ? count_q : count_q + 1'b1;
	assign total_wide  = WIDE_W'(count_inc);
	assign total_clamp = (total_wide > WIDE_W'(jse_pkg::TOTAL_MAX)) ? jse_pkg::TOTAL_MAX
		: total_wide[19:0];

	assign load = head_valid && (!ovalid_q || out_bytes.ready);
	assign pop  = load && last_slot;

	// Sequencer position and string count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else if (load) begin
			idx_q   <= last_slot ? 3'd0 : idx_q + 3'd1;
			count_q <= is_open ? COUNT_BITS'(1) : count_inc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (out_bytes.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_end_q  <= last_slot;
			done_q     <= is_close;
			total_q    <= is_close ? total_clamp : 20'd0;
		end
	end

	assign out_bytes.valid         = ovalid_q;
	assign out_bytes.out_byte      = out_byte_q;
	assign out_bytes.run_end       = run_end_q;
	assign out_bytes.string_done   = done_q;
	assign out_bytes.total_written = total_q;

	a_done_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && done_q) |-> (out_byte_q == jse_pkg::CH_QUOTE))
		else $error("string_done on a byte other than the closing quote");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && done_q) |-> run_end_q)
		else $error("closing quote is not the last beat of its item");

	a_total_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !done_q) |-> (total_q == 20'd0))
		else $error("total_written nonzero outside the closing quote");

	a_done_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && done_q) |-> (total_q != 20'd0))
		else $error("closing quote reports a zero total");

endmodule

// ----- rtl/core/json_string_escaper.sv -----
`timescale 1ns / 1ps

// JSON string escaper. Each input beat carries one string byte with first, last
// and has_byte flags; the output is the byte stream of the JSON literal (opening
// quote, escaped byte, closing quote), one byte per beat, with run_end on the last
// byte of each input beat and the saturating byte total on the closing quote. A
// front end classifies each beat and writes it into a four-entry queue; the back
// end sequencer emits one output byte per cycle while the output is ready. Plain
// bytes therefore sustain one input beat per cycle under the same condition; a
// beat that expands to n output bytes (up to 8: quote, six-byte \u00xx sequence,
// quote) holds the back end until its last byte is loaded, while the front keeps
// taking beats until the queue fills. A queued beat goes through its queue entry
// and then the output register. Beats with no byte and no flags are taken and dropped.
module json_string_escaper #(
	parameter int COUNT_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	jse_in_if.sink      in_bytes,
	jse_out_if.source   out_bytes
);

	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;
	jse_pkg::desc_t push_desc;
	jse_pkg::desc_t head;

	jse_front u_front (
		.in_bytes  (in_bytes),
		.full      (full),
		.push      (push),
		.push_desc (push_desc)
	);

	jse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	jse_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_bytes  (out_bytes)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int COUNT_BITS   = 20;
	localparam int RANDOM_ITEMS = 147;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_LIMIT  = 50;
	localparam int TOTAL_W      = jse_pkg::TOTAL_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_byte;
		logic       is_first;
		logic       is_last;
	} str_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        run_end;
		logic        string_done;
		logic [19:0] total_written;
	} lit_beat_t;

	// exp_len == 0: output comes from the escape predictor
	typedef struct packed {
		str_beat_t   beat;
		logic [3:0]  exp_len;
		logic [63:0] exp_text;
		logic [19:0] exp_total;
	} stim_row_t;

	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PATTERN,
		SINK_CHOKED
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	jse_in_if  in_bytes();
	jse_out_if out_bytes();

	json_string_escaper #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_bytes (in_bytes),
		.out_bytes(out_bytes)
	);

	always #10 clk = ~clk;

	lit_beat_t             literal_q[$];
	logic [COUNT_BITS-1:0] bytes_so_far = '0;
	int                    mismatch_count = 0;
	int                    idle_cycles = 0;
	int                    burst_left = 0;
	sink_mode_t            sink_mode = SINK_OPEN;
	int                    phase_left = 0;

	// Directed strings: extremes, every escape form, flag corner cases
	stim_row_t directed_rows [23] = '{
		'{'{8'h00, 1'b0, 1'b1, 1'b1}, 4'd2, "\"\"", 20'd2},           // empty string
		'{'{8'h00, 1'b1, 1'b1, 1'b1}, 4'd8, "\"\\u0000\"", 20'd8},    // NUL as \u0000
		'{'{8'hFF, 1'b1, 1'b1, 1'b1}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::C_HT, 1'b1, 1'b1, 1'b1}, 4'd4, "\"\\t\"", 20'd4},
		'{'{8'h00, 1'b0, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},            // no byte, no flags
		'{'{jse_pkg::CH_QUOTE,  1'b1, 1'b1, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::C_BS, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::C_FF, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::C_LF, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::C_CR, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{jse_pkg::CTRL_MAX, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h1A, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h01, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h20, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h7F, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h80, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},
		'{'{8'h41, 1'b1, 1'b1, 1'b0}, 4'd0, 64'd0, 20'd0},            // restart mid-string
		'{'{8'h00, 1'b0, 1'b0, 1'b1}, 4'd0, 64'd0, 20'd0},            // close without a byte
		'{'{8'h55, 1'b1, 1'b0, 1'b0}, 4'd0, 64'd0, 20'd0},            // byte outside a string
		'{'{8'h00, 1'b0, 1'b1, 1'b0}, 4'd0, 64'd0, 20'd0},            // open without a byte
		'{'{8'hAA, 1'b1, 1'b0, 1'b1}, 4'd0, 64'd0, 20'd0},
		'{'{8'h2F, 1'b1, 1'b1, 1'b1}, 4'd0, 64'd0, 20'd0}
	};

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? jse_pkg::CH_ZERO + 8'(nib) : "a" + 8'(nib - 4'd10);
	endfunction

	// Escape one string beat into literal bytes; tracks the saturating byte count
	function automatic void escape_beat(input str_beat_t b, ref lit_beat_t res[$]);
		logic [7:0] seq[$];
		lit_beat_t  r;
		if (b.is_first) begin
			bytes_so_far = '0;
			seq.push_back(jse_pkg::CH_QUOTE);
		end
		if (b.has_byte) begin
			if (b.char_byte == jse_pkg::CH_QUOTE || b.char_byte == jse_pkg::CH_BSLASH) begin
				seq.push_back(jse_pkg::CH_BSLASH);
				seq.push_back(b.char_byte);
			end else if (b.char_byte <= jse_pkg::CTRL_MAX) begin
				seq.push_back(jse_pkg::CH_BSLASH);
				case (b.char_byte)
					jse_pkg::C_BS: seq.push_back(jse_pkg::CH_B);
					jse_pkg::C_FF: seq.push_back(jse_pkg::CH_F);
					jse_pkg::C_LF: seq.push_back(jse_pkg::CH_N);
					jse_pkg::C_CR: seq.push_back(jse_pkg::CH_R);
					jse_pkg::C_HT: seq.push_back(jse_pkg::CH_T);
					default: begin
						seq.push_back(jse_pkg::CH_U);
						seq.push_back(jse_pkg::CH_ZERO);
						seq.push_back(jse_pkg::CH_ZERO);
						seq.push_back(hex_digit(b.char_byte[7:4]));
						seq.push_back(hex_digit(b.char_byte[3:0]));
					end
				endcase
			end else begin
				seq.push_back(b.char_byte);
			end
		end
		if (b.is_last)
			seq.push_back(jse_pkg::CH_QUOTE);
		foreach (seq[k]) begin
			if (bytes_so_far != COUNT_MAX)
				bytes_so_far++;
			r.out_byte      = seq[k];
			r.run_end       = (k == seq.size() - 1);
			r.string_done   = b.is_last && r.run_end;
			r.total_written = !r.string_done ? '0 :
				(bytes_so_far > jse_pkg::TOTAL_MAX) ? jse_pkg::TOTAL_MAX
				: TOTAL_W'(bytes_so_far);
			res.push_back(r);
		end
	endfunction

	function automatic logic [7:0] random_char();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 31));
			1: begin
				case ($urandom_range(0, 6))
					0: return jse_pkg::CH_QUOTE;
					1: return jse_pkg::CH_BSLASH;
					2: return jse_pkg::C_BS;
					3: return jse_pkg::C_FF;
					4: return jse_pkg::C_LF;
					5: return jse_pkg::C_CR;
					default: return jse_pkg::C_HT;
				endcase
			end
			2: return 8'($urandom);
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Drive one beat in a burst, wait for the handshake, then queue its bytes
	task automatic send_beat(input stim_row_t row);
		lit_beat_t pred[$];
		lit_beat_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_bytes.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_bytes.valid     <= 1'b1;
		in_bytes.char_byte <= row.beat.char_byte;
		in_bytes.has_byte  <= row.beat.has_byte;
		in_bytes.is_first  <= row.beat.is_first;
		in_bytes.is_last   <= row.beat.is_last;
		do @(posedge clk); while (!in_bytes.ready);
		escape_beat(row.beat, pred);
		if (row.exp_len == 0) begin
			foreach (pred[k])
				literal_q.push_back(pred[k]);
		end else begin
			for (int k = 0; k < row.exp_len; k++) begin
				r.out_byte      = row.exp_text[8 * (row.exp_len - 1 - k) +: 8];
				r.run_end       = (k == row.exp_len - 1);
				r.string_done   = r.run_end && row.beat.is_last;
				r.total_written = r.string_done ? row.exp_total : '0;
				literal_q.push_back(r);
			end
		end
	endtask

	// Stimulus: directed table, then random strings with some noise
	initial begin
		stim_row_t row;
		int sent;
		int str_len;
		arst_n             = 1'b0;
		in_bytes.valid     = 1'b0;
		in_bytes.char_byte = '0;
		in_bytes.has_byte  = 1'b0;
		in_bytes.is_first  = 1'b0;
		in_bytes.is_last   = 1'b0;
		out_bytes.ready    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i]);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			row = '0;
			if ($urandom_range(0, 99) < 85) begin
				str_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) :
					$urandom_range(0, 10);
				if (str_len == 0) begin
					row.beat = '{8'($urandom), 1'b1 == 1'b0, 1'b1, 1'b1};
					send_beat(row);
					sent++;
				end
				for (int k = 0; k < str_len; k++) begin
					row.beat = '{random_char(), 1'b1, k == 0, k == str_len - 1};
					send_beat(row);
					sent++;
				end
			end else begin
				// broken framing: any flag combination
				row.beat = '{8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)};
				send_beat(row);
				if (row.beat.has_byte || row.beat.is_first || row.beat.is_last)
					sent++;
			end
		end
		in_bytes.valid <= 1'b0;

		while (literal_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && literal_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Output sink: picks a new random back-pressure mode at the end of each random-length phase
	always @(posedge clk) begin
		if (phase_left == 0) begin
			sink_mode  = sink_mode_t'($urandom_range(0, 3));
			phase_left = $urandom_range(20, 120);
		end
		phase_left--;
		case (sink_mode)
			SINK_OPEN:    out_bytes.ready <= 1'b1;
			SINK_RANDOM:  out_bytes.ready <= ($urandom_range(0, 2) != 0);
			SINK_PATTERN: out_bytes.ready <= ((phase_left % 8) >= 3);
			default:      out_bytes.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Compare each output beat with the oldest expected byte
	always @(posedge clk) begin
		lit_beat_t want;
		if (arst_n && out_bytes.valid && out_bytes.ready) begin
			if (literal_q.size() == 0) begin
				report_mismatch("unexpected beat, out_byte", 32'(out_bytes.out_byte), 0);
			end else begin
				want = literal_q.pop_front();
				if (out_bytes.out_byte !== want.out_byte)
					report_mismatch("out_byte", 32'(out_bytes.out_byte), 32'(want.out_byte));
				if (out_bytes.run_end !== want.run_end)
					report_mismatch("run_end", 32'(out_bytes.run_end), 32'(want.run_end));
				if (out_bytes.string_done !== want.string_done)
					report_mismatch("string_done", 32'(out_bytes.string_done),
						32'(want.string_done));
				if (out_bytes.total_written !== want.total_written)
					report_mismatch("total_written", 32'(out_bytes.total_written),
						32'(want.total_written));
			end
		end
	end

	// Watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if ((in_bytes.valid && in_bytes.ready) || (out_bytes.valid && out_bytes.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
